### rtl/core/dpdm_pkg.sv
// Shared widths, register codes, configuration struct and saturation helper.
package dpdm_pkg;

    localparam int RANGE_W    = 13;
    localparam int DIST_W     = 10;
    localparam int ERR_W      = 11;
    localparam int GAIN_W     = 16;
    localparam int DB_W       = 10;
    localparam int MAXSPD_W   = 12;
    localparam int SPEED_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SAT_IN_W   = 24;

    // Divide by ten as a multiply by ceil(2^19 / 10) and a shift; exact for
    // every 13-bit range reading.
    localparam int               DIV10_SHIFT = 19;
    localparam logic [15:0]      DIV10_RECIP = 16'd52429;
    localparam int               DIV10_PROD_W = RANGE_W + 16;

    localparam logic signed [SAT_IN_W-1:0] SAT_MAX = SAT_IN_W'(32767);
    localparam logic signed [SAT_IN_W-1:0] SAT_MIN = -SAT_IN_W'(32768);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GOAL_CM       = 3'd0,
        CFG_FWD_LIMIT     = 3'd1,
        CFG_KP_DIST       = 3'd2,
        CFG_KD_DIST       = 3'd3,
        CFG_DIST_DEADBAND = 3'd4,
        CFG_KP_TURN       = 3'd5,
        CFG_KD_TURN       = 3'd6,
        CFG_TURN_DEADBAND = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [DIST_W-1:0]   goal_cm;
        logic [MAXSPD_W-1:0] fwd_limit;
        logic [GAIN_W-1:0]   kp_dist;
        logic [GAIN_W-1:0]   kd_dist;
        logic [DB_W-1:0]     dist_deadband;
        logic [GAIN_W-1:0]   kp_turn;
        logic [GAIN_W-1:0]   kd_turn;
        logic [DB_W-1:0]     turn_deadband;
    } cfg_t;

    // Clamp a signed value to the 16-bit signed range.
    function automatic logic signed [SPEED_W-1:0] sat16(input logic signed [SAT_IN_W-1:0] v);
        logic signed [SPEED_W-1:0] r;
        if (v > SAT_MAX) begin
            r = SPEED_W'(SAT_MAX);
        end else if (v < SAT_MIN) begin
            r = SPEED_W'(SAT_MIN);
        end else begin
            r = SPEED_W'(v);
        end
        return r;
    endfunction

endpackage

### rtl/core/dpdm_cfg_regs.sv
// Configuration register file with write port and reset values.
module dpdm_cfg_regs import dpdm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.goal_cm       <= DIST_W'(8);
            cfg_reg.fwd_limit     <= MAXSPD_W'(600);
            cfg_reg.kp_dist       <= GAIN_W'(256);
            cfg_reg.kd_dist       <= '0;
            cfg_reg.dist_deadband <= DB_W'(1);
            cfg_reg.kp_turn       <= GAIN_W'(256);
            cfg_reg.kd_turn       <= '0;
            cfg_reg.turn_deadband <= DB_W'(10);
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GOAL_CM:       cfg_reg.goal_cm       <= cfg_data[DIST_W-1:0];
                CFG_FWD_LIMIT:     cfg_reg.fwd_limit     <= cfg_data[MAXSPD_W-1:0];
                CFG_KP_DIST:       cfg_reg.kp_dist       <= cfg_data[GAIN_W-1:0];
                CFG_KD_DIST:       cfg_reg.kd_dist       <= cfg_data[GAIN_W-1:0];
                CFG_DIST_DEADBAND: cfg_reg.dist_deadband <= cfg_data[DB_W-1:0];
                CFG_KP_TURN:       cfg_reg.kp_turn       <= cfg_data[GAIN_W-1:0];
                CFG_KD_TURN:       cfg_reg.kd_turn       <= cfg_data[GAIN_W-1:0];
                CFG_TURN_DEADBAND: cfg_reg.turn_deadband <= cfg_data[DB_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/core/dpdm_pd.sv
// One PD term with deadband: Q8.8 gains, truncation toward zero, 16-bit saturation.
module dpdm_pd import dpdm_pkg::*; (
    input  logic signed [ERR_W-1:0]   err,
    input  logic signed [ERR_W-1:0]   last_err,
    input  logic [GAIN_W-1:0]         kp,
    input  logic [GAIN_W-1:0]         kd,
    input  logic [DB_W-1:0]           deadband,
    output logic signed [SPEED_W-1:0] term,
    output logic                      active
);

    localparam int PPROD_W = GAIN_W + 1 + ERR_W;
    localparam int DPROD_W = GAIN_W + 1 + ERR_W + 1;
    localparam int ACC_W   = DPROD_W + 1;
    localparam int FRAC_W  = 8;
    localparam int QUO_W   = ACC_W - FRAC_W;

    logic [ERR_W-1:0]          mag;
    logic signed [ERR_W:0]     diff;
    logic signed [PPROD_W-1:0] p_prod;
    logic signed [DPROD_W-1:0] d_prod;
    logic signed [ACC_W-1:0]   acc;
    logic                      round_up;
    logic signed [QUO_W-1:0]   quo;

    // The magnitude of the most negative error still fits unsigned.
    assign mag    = err[ERR_W-1] ? (~err + ERR_W'(1)) : err;
    assign active = (mag >= ERR_W'(deadband));

    assign diff   = {err[ERR_W-1], err} - {last_err[ERR_W-1], last_err};
    assign p_prod = $signed({1'b0, kp}) * err;
    assign d_prod = $signed({1'b0, kd}) * diff;
    assign acc    = {{(ACC_W - PPROD_W){p_prod[PPROD_W-1]}}, p_prod}
                  + {{(ACC_W - DPROD_W){d_prod[DPROD_W-1]}}, d_prod};

    // Arithmetic shift floors; a negative value with a remainder moves up by one.
    assign round_up = acc[ACC_W-1] & (|acc[FRAC_W-1:0]);
    assign quo      = $signed(acc[ACC_W-1:FRAC_W]) + $signed({{(QUO_W-1){1'b0}}, round_up});

    assign term = active ? sat16(SAT_IN_W'(quo)) : '0;

endmodule

### rtl/core/dual_pd_drive_mixer_core.sv
// Top level of the differential drive mixer with distance and line PD regulators.
//
//   Channel  Direction  Handshake          Payload
//   s_       in         s_valid / s_ready  s_range_mm, s_go, s_line_error
//   m_       out        m_valid / m_ready  m_left_speed, m_right_speed
//   cfg_     in         cfg_wr_en          cfg_index, cfg_data
//
// An item is registered in the input register on acceptance (with its range
// already converted to centimeters) and its wheel speeds then in the result
// register; one item can be taken every cycle while the output is not stalled.
// Both PD terms and their previous-error state are evaluated in the single
// stage between the input register and the result register.
// A stall on m_ready holds the result register and the input register; the
// input side keeps accepting as long as the input register can drain.
// Synchronous active-low reset clears the valid flags, the error history and
// the configuration registers to their defaults.
module dual_pd_drive_mixer_core import dpdm_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [RANGE_W-1:0]        s_range_mm,
    input  logic                      s_go,
    input  logic signed [ERR_W-1:0]   s_line_error,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [SPEED_W-1:0] m_left_speed,
    output logic signed [SPEED_W-1:0] m_right_speed,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    cfg_t cfg;

    // Input register stage.
    logic                      in_valid_reg;
    logic [DIST_W-1:0]         dist_reg;
    logic                      go_reg;
    logic signed [ERR_W-1:0]   line_reg;

    // Result register stage.
    logic                      out_valid_reg;
    logic signed [SPEED_W-1:0] left_reg;
    logic signed [SPEED_W-1:0] right_reg;

    // Previous errors carried from item to item.
    logic signed [ERR_W-1:0]   last_dist_err_reg;
    logic signed [ERR_W-1:0]   last_line_err_reg;

    logic                      advance;
    logic                      s_accept;
    logic [DIV10_PROD_W-1:0]   div_prod;
    logic [DIST_W-1:0]         dist_next;
    logic                      beyond_goal;
    logic signed [ERR_W-1:0]   dist_err;
    logic signed [SPEED_W-1:0] dist_term;
    logic                      dist_active;
    logic signed [SPEED_W-1:0] turn_term;
    logic                      turn_active;
    logic signed [SPEED_W-1:0] fwd;
    logic signed [SPEED_W:0]   left_sum;
    logic signed [SPEED_W:0]   right_sum;
    logic                      dist_update;
    logic                      line_update;

    dpdm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The held item moves into the result register whenever that register
    // is empty or its item is being taken this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    // Millimeters to centimeters, truncating, by reciprocal multiplication.
    assign div_prod  = {16'b0, s_range_mm} * {{RANGE_W{1'b0}}, DIV10_RECIP};
    assign dist_next = div_prod[DIV10_SHIFT +: DIST_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            dist_reg <= dist_next;
            go_reg   <= s_go;
            line_reg <= s_line_error;
        end
    end

    // Distance regulation only applies at or inside the goal distance.
    assign beyond_goal = (dist_reg > cfg.goal_cm);
    assign dist_err    = $signed({1'b0, dist_reg}) - $signed({1'b0, cfg.goal_cm});

    dpdm_pd u_pd_dist (
        .err      (dist_err),
        .last_err (last_dist_err_reg),
        .kp       (cfg.kp_dist),
        .kd       (cfg.kd_dist),
        .deadband (cfg.dist_deadband),
        .term     (dist_term),
        .active   (dist_active)
    );

    dpdm_pd u_pd_turn (
        .err      (line_reg),
        .last_err (last_line_err_reg),
        .kp       (cfg.kp_turn),
        .kd       (cfg.kd_turn),
        .deadband (cfg.turn_deadband),
        .term     (turn_term),
        .active   (turn_active)
    );

    always_comb begin
        if (!go_reg) begin
            fwd = '0;
        end else if (beyond_goal) begin
            fwd = $signed({{(SPEED_W - MAXSPD_W){1'b0}}, cfg.fwd_limit});
        end else begin
            fwd = dist_term;
        end
    end

    assign left_sum  = {fwd[SPEED_W-1], fwd} + {turn_term[SPEED_W-1], turn_term};
    assign right_sum = {fwd[SPEED_W-1], fwd} - {turn_term[SPEED_W-1], turn_term};

    // A stopped item or one beyond the goal leaves the distance history alone,
    // and so does any error inside its deadband.
    assign dist_update = advance && go_reg && !beyond_goal && dist_active;
    assign line_update = advance && turn_active;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_dist_err_reg <= '0;
            last_line_err_reg <= '0;
        end else begin
            if (dist_update) begin
                last_dist_err_reg <= dist_err;
            end
            if (line_update) begin
                last_line_err_reg <= line_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            left_reg  <= sat16(SAT_IN_W'(left_sum));
            right_reg <= sat16(SAT_IN_W'(right_sum));
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_left_speed  = left_reg;
    assign m_right_speed = right_reg;

`ifndef SYNTHESIS
    // A held item never overwrites a result that is still stalled.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |-> !s_ready)
        else $error("input stage advanced into a stalled result");

    // Moving an item forward always presents a result in the next cycle.
    a_advance_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("advanced item produced no result");

    // A stopped item leaves the distance history untouched.
    a_stop_keeps_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !go_reg) |=> $stable(last_dist_err_reg))
        else $error("distance history changed on a stopped item");

    // Without an item moving forward, neither error history changes.
    a_history_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> ($stable(last_dist_err_reg) && $stable(last_line_err_reg)))
        else $error("error history changed without an item");
`endif

endmodule

### tb/sv/tb_dual_pd_drive_mixer_core.sv
// Self-checking testbench for the dual PD drive mixer core with its own speed predictor.
module tb_dual_pd_drive_mixer_core;
    import dpdm_pkg::*;

    // One pair of wheel speeds as the block should produce it.
    typedef struct {
        logic signed [SPEED_W-1:0] left;
        logic signed [SPEED_W-1:0] right;
    } wheel_pair_t;

    // How the result side paces its ready signal.
    typedef enum int { RX_ALWAYS, RX_RANDOM, RX_PATTERN } rx_mode_t;

    // Kinds of register settings used between phases.
    typedef enum int { SET_TYPICAL, SET_RAW, SET_MAX, SET_MIN } settings_style_t;

    localparam int CLK_PERIOD   = 4;
    localparam int CM_DIVISOR   = 10;
    localparam int Q_SCALE      = 256;
    localparam int PIPE_LATENCY = 2;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int LIMIT_CYCLES = 400000;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_ITEMS  = 210;
    localparam int HOLD_CYCLES  = 300;

    logic                      aclk         = 1'b0;
    logic                      aresetn      = 1'b0;
    logic                      s_valid      = 1'b0;
    logic                      s_ready;
    logic [RANGE_W-1:0]        s_range_mm   = '0;
    logic                      s_go         = 1'b0;
    logic signed [ERR_W-1:0]   s_line_error = '0;
    logic                      m_valid;
    logic                      m_ready      = 1'b0;
    logic signed [SPEED_W-1:0] m_left_speed;
    logic signed [SPEED_W-1:0] m_right_speed;
    logic                      cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index    = '0;
    logic [CFG_DATA_W-1:0]     cfg_data     = '0;

    // Predictor copy of the registers and of the two previous errors.
    cfg_t        drive_cfg;
    int          prev_dist_err;
    int          prev_line_err;
    wheel_pair_t pending_speeds[$];
    int          error_count = 0;

    // Sender pacing: items go out in bursts, with a random gap bounded by gap_max between.
    int burst_left = 0;
    int gap_max    = 0;

    // Receiver pacing. A long hold-off is requested by bumping hold_token; the receiver
    // counts the cycles itself so that the sender can keep offering items meanwhile.
    rx_mode_t rx_mode      = RX_ALWAYS;
    int       rx_stall_pct = 0;
    int       rx_phase     = 0;
    int       hold_token   = 0;
    int       hold_len     = 0;
    int       hold_seen    = 0;
    int       hold_cnt     = 0;

    dual_pd_drive_mixer_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_range_mm    (s_range_mm),
        .s_go          (s_go),
        .s_line_error  (s_line_error),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_left_speed  (m_left_speed),
        .m_right_speed (m_right_speed),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // The run is cut off here if the block stops producing results.
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("dual_pd_drive_mixer_core test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Speed predictor
    // ------------------------------------------------------------------

    function automatic longint clamp_speed(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // One PD regulator. Inside the deadband it gives zero and keeps its previous
    // error; otherwise the Q8.8 sum is truncated toward zero and clamped.
    function automatic longint pd_output(input int err, input int last, input int kp,
                                         input int kd, input int deadband,
                                         output int next_last);
        int     mag;
        longint acc;
        mag = (err < 0) ? -err : err;
        next_last = last;
        if (mag < deadband) return 0;
        acc = longint'(kp) * longint'(err) + longint'(kd) * longint'(err - last);
        next_last = err;
        return clamp_speed(acc / Q_SCALE);
    endfunction

    // Works out the wheel speeds of one accepted item and queues them.
    task automatic predict_speeds(input logic [RANGE_W-1:0] range_mm, input logic go,
                                  input logic signed [ERR_W-1:0] line_err);
        int          dist_cm;
        int          goal;
        int          next_last;
        longint      fwd;
        longint      corr;
        wheel_pair_t w;
        fwd = 0;
        // With go low the distance regulator is skipped and keeps its history.
        if (go) begin
            dist_cm = int'(range_mm) / CM_DIVISOR;
            goal = int'(drive_cfg.goal_cm);
            if (dist_cm > goal) begin
                fwd = longint'(drive_cfg.fwd_limit);
            end else begin
                fwd = pd_output(dist_cm - goal, prev_dist_err, int'(drive_cfg.kp_dist),
                                int'(drive_cfg.kd_dist), int'(drive_cfg.dist_deadband),
                                next_last);
                prev_dist_err = next_last;
            end
        end
        // The line regulator runs on every item.
        corr = pd_output(int'(line_err), prev_line_err, int'(drive_cfg.kp_turn),
                         int'(drive_cfg.kd_turn), int'(drive_cfg.turn_deadband), next_last);
        prev_line_err = next_last;
        w.left  = SPEED_W'(clamp_speed(fwd + corr));
        w.right = SPEED_W'(clamp_speed(fwd - corr));
        pending_speeds.push_back(w);
    endtask

    task automatic reset_model();
        drive_cfg.goal_cm       = 10'd8;
        drive_cfg.fwd_limit     = 12'd600;
        drive_cfg.kp_dist       = 16'd256;
        drive_cfg.kd_dist       = 16'd0;
        drive_cfg.dist_deadband = 10'd1;
        drive_cfg.kp_turn       = 16'd256;
        drive_cfg.kd_turn       = 16'd0;
        drive_cfg.turn_deadband = 10'd10;
        prev_dist_err = 0;
        prev_line_err = 0;
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
    endtask

    // Every accepted result is compared field by field with the oldest expectation.
    always @(posedge aclk) begin : speed_check
        wheel_pair_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_speeds.size() == 0) begin
                flag_error($sformatf("result with nothing expected: left %0d right %0d",
                                     m_left_speed, m_right_speed));
            end else begin
                want = pending_speeds.pop_front();
                if (m_left_speed !== want.left || m_right_speed !== want.right) begin
                    flag_error($sformatf("left expected %0d got %0d, right expected %0d got %0d",
                                         want.left, m_left_speed, want.right, m_right_speed));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side pacing
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        rx_phase = (rx_phase == 10) ? 0 : rx_phase + 1;
        if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            m_ready <= 1'b0;
        end else if (hold_seen != hold_token) begin
            // A new hold-off was asked for; ready stays low while hold_cnt counts down.
            hold_seen = hold_token;
            hold_cnt  = hold_len - 1;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: m_ready <= 1'b1;
                RX_RANDOM: m_ready <= (int'($urandom_range(99, 0)) >= rx_stall_pct);
                default:   m_ready <= (rx_phase < 8);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input and register drivers. Every task returns in the time step of a
    // rising edge, so the next one can drive without losing a cycle.
    // ------------------------------------------------------------------

    // Offers one item and returns at the edge where it is taken. Valid is left
    // high so that a following item in the same burst goes out back to back.
    task automatic send_reading(input int range_mm, input int go, input int line_err);
        int                      gap;
        logic [RANGE_W-1:0]      r;
        logic                    g;
        logic signed [ERR_W-1:0] l;
        r = RANGE_W'(range_mm);
        g = 1'(go);
        l = ERR_W'(line_err);
        if (burst_left == 0) begin
            gap = (gap_max > 0) ? int'($urandom_range(gap_max, 1)) : 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = int'($urandom_range(16, 1));
        end
        s_valid      <= 1'b1;
        s_range_mm   <= r;
        s_go         <= g;
        s_line_error <= l;
        do @(posedge aclk); while (!s_ready);
        predict_speeds(r, g, l);
        burst_left--;
    endtask

    // Drops valid and waits until every expected result has come out, plus the
    // pipeline latency, so that registers can be changed safely.
    task automatic wait_idle();
        int guard;
        s_valid <= 1'b0;
        burst_left = 0;
        guard = 0;
        while (pending_speeds.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (PIPE_LATENCY + 2) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        // The block keeps only as many low bits as the register is wide.
        case (idx)
            CFG_GOAL_CM:       drive_cfg.goal_cm       = value[DIST_W-1:0];
            CFG_FWD_LIMIT:     drive_cfg.fwd_limit     = value[MAXSPD_W-1:0];
            CFG_KP_DIST:       drive_cfg.kp_dist       = value[GAIN_W-1:0];
            CFG_KD_DIST:       drive_cfg.kd_dist       = value[GAIN_W-1:0];
            CFG_DIST_DEADBAND: drive_cfg.dist_deadband = value[DB_W-1:0];
            CFG_KP_TURN:       drive_cfg.kp_turn       = value[GAIN_W-1:0];
            CFG_KD_TURN:       drive_cfg.kd_turn       = value[GAIN_W-1:0];
            default:           drive_cfg.turn_deadband = value[DB_W-1:0];
        endcase
    endtask

    task automatic program_settings(input logic [CFG_DATA_W-1:0] goal, maxspd, kpd, kdd, dbd,
                                    input logic [CFG_DATA_W-1:0] kpt, kdt, dbt);
        write_reg(CFG_GOAL_CM, goal);
        write_reg(CFG_FWD_LIMIT, maxspd);
        write_reg(CFG_KP_DIST, kpd);
        write_reg(CFG_KD_DIST, kdd);
        write_reg(CFG_DIST_DEADBAND, dbd);
        write_reg(CFG_KP_TURN, kpt);
        write_reg(CFG_KD_TURN, kdt);
        write_reg(CFG_TURN_DEADBAND, dbt);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_setting(input settings_style_t style,
                                                           input int lo, input int hi,
                                                           input int top_val);
        case (style)
            SET_MAX: return CFG_DATA_W'(top_val);
            SET_MIN: return '0;
            // Raw 16-bit data also checks that narrow registers drop the upper bits.
            SET_RAW: return CFG_DATA_W'($urandom_range(65535, 0));
            default: return CFG_DATA_W'($urandom_range(hi, lo));
        endcase
    endfunction

    task automatic random_settings(input settings_style_t style);
        program_settings(pick_setting(style, 2, 100, 1023),
                         pick_setting(style, 0, 2200, 4095),
                         pick_setting(style, 0, 2048, 65535),
                         pick_setting(style, 0, 2048, 65535),
                         pick_setting(style, 0, 5, 1023),
                         pick_setting(style, 0, 2048, 65535),
                         pick_setting(style, 0, 2048, 65535),
                         pick_setting(style, 0, 30, 1023));
    endtask

    // Random item, weighted toward ranges near the goal, mostly below it, so that the
    // distance regulator is busy, and toward line errors around the deadband.
    function automatic void random_reading(output int range_mm, output int go,
                                           output int line_err);
        int pick;
        int db;
        pick = int'($urandom_range(99, 0));
        if (pick < 55) begin
            range_mm = int'(drive_cfg.goal_cm) * CM_DIVISOR - 200
                       + int'($urandom_range(240, 0));
        end else if (pick < 90) begin
            range_mm = int'($urandom_range(8191, 0));
        end else begin
            range_mm = ($urandom_range(1, 0) == 1) ? 8191 : 0;
        end
        if (range_mm < 0) range_mm = 0;
        if (range_mm > 8191) range_mm = 8191;
        go = ($urandom_range(99, 0) < 85) ? 1 : 0;
        pick = int'($urandom_range(99, 0));
        if (pick < 70) begin
            line_err = int'($urandom_range(1280, 0)) - 640;
        end else if (pick < 85) begin
            db = int'(drive_cfg.turn_deadband);
            line_err = db - 2 + int'($urandom_range(4, 0));
            if ($urandom_range(1, 0) == 1) line_err = -line_err;
        end else if (pick < 95) begin
            line_err = int'($urandom_range(2047, 0)) - 1024;
        end else begin
            case ($urandom_range(3, 0))
                0:       line_err = -1024;
                1:       line_err = 1023;
                2:       line_err = -640;
                default: line_err = 640;
            endcase
        end
        if (line_err < -1024) line_err = -1024;
        if (line_err > 1023) line_err = 1023;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings: goal 8 cm, max speed 600, unit proportional gains, no
    // derivative, deadbands 1 and 10.
    task automatic test_reset_defaults();
        gap_max = 0;
        rx_mode = RX_ALWAYS;
        send_reading(80, 1, 0);       // exactly at the goal, inside the distance deadband
        send_reading(79, 1, 9);       // one cm short; line error just inside its deadband
        send_reading(90, 1, 10);      // beyond the goal; line error on the deadband edge
        send_reading(0, 1, -10);
        send_reading(8191, 1, 640);
        send_reading(8191, 0, -640);  // stop: distance regulator skipped
        send_reading(0, 0, 1023);
        send_reading(5, 1, -1024);
        send_reading(89, 1, -9);
        wait_idle();
    endtask

    // Largest and smallest register values, with saturation of both regulators
    // and of the wheel sums, and a goal above any reachable distance.
    task automatic test_extreme_settings();
        rx_mode = RX_RANDOM;
        rx_stall_pct = 30;
        program_settings(16'd1023, 16'd4095, 16'hFFFF, 16'hFFFF, 16'd0,
                         16'hFFFF, 16'hFFFF, 16'd0);
        send_reading(8191, 1, 1023);
        send_reading(0, 1, -1024);
        send_reading(0, 0, -1024);    // stop keeps the distance history
        send_reading(4000, 1, 0);
        send_reading(8191, 1, 1);
        wait_idle();
        // Widest deadbands: only the largest errors get through.
        program_settings(16'd1023, 16'd4095, 16'hFFFF, 16'hFFFF, 16'd1023,
                         16'hFFFF, 16'hFFFF, 16'd1023);
        send_reading(0, 1, -1024);
        send_reading(10, 1, 1022);
        send_reading(8191, 1, 640);
        wait_idle();
        // Everything at zero: a zero deadband still runs the regulator at zero error.
        program_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_reading(0, 1, 0);
        send_reading(9, 1, 5);
        send_reading(10, 1, -5);
        wait_idle();
    endtask

    // Several register settings, each with its own mix of sender gaps and
    // receiver stalls, including phases where neither side idles.
    task automatic test_random_phases();
        int              range_mm;
        int              go;
        int              line_err;
        settings_style_t style;
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            wait_idle();
            case (phase)
                2:       style = SET_MAX;
                5:       style = SET_MIN;
                6:       style = SET_RAW;
                default: style = SET_TYPICAL;
            endcase
            random_settings(style);
            case (phase % 3)
                0:       gap_max = 0;
                1:       gap_max = 3;
                default: gap_max = 10;
            endcase
            rx_mode = rx_mode_t'((phase / 3 + phase) % 3);
            rx_stall_pct = int'($urandom_range(60, 10));
            repeat (PHASE_ITEMS) begin
                random_reading(range_mm, go, line_err);
                send_reading(range_mm, go, line_err);
            end
        end
        wait_idle();
    endtask

    // The receiver holds off for a long stretch while items keep coming, so the
    // block fills up and has to stall its input.
    task automatic test_backpressure();
        int range_mm;
        int go;
        int line_err;
        random_settings(SET_TYPICAL);
        gap_max = 0;
        rx_mode = RX_ALWAYS;
        hold_len = HOLD_CYCLES;
        hold_token = hold_token + 1;
        repeat (40) begin
            random_reading(range_mm, go, line_err);
            send_reading(range_mm, go, line_err);
        end
        wait_idle();
    endtask

    initial begin
        reset_model();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_extreme_settings();
        test_random_phases();
        test_backpressure();
        wait_idle();
        if (pending_speeds.size() != 0) begin
            $display("ERROR: %0d expected results never arrived", pending_speeds.size());
        end
        if (error_count == 0 && pending_speeds.size() == 0) begin
            $display("dual_pd_drive_mixer_core test passed");
        end else begin
            $display("dual_pd_drive_mixer_core test failed");
        end
        $finish;
    end

endmodule
